// ===== hdl/ring_neighbour_exclusion_arbiter_top_macros.svh =====
`ifndef RING_NEIGHBOUR_EXCLUSION_ARBITER_TOP_MACROS_SVH
`define RING_NEIGHBOUR_EXCLUSION_ARBITER_TOP_MACROS_SVH

// same-cycle implication
`define RNEA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RNEA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rnea_pkg.sv =====
package rnea_pkg;

    localparam int SEAT_W      = 4;
    localparam int STATE_W     = 2;
    localparam int CFG_W       = 5;
    localparam int SEATS_RESET = 5;

    typedef logic [SEAT_W-1:0]  seat_idx_t;
    typedef logic [STATE_W-1:0] seat_state_t;
    typedef logic [CFG_W-1:0]   ring_idx_t;

    localparam seat_state_t ST_THINKING = 2'd0;
    localparam seat_state_t ST_HUNGRY   = 2'd1;
    localparam seat_state_t ST_EATING   = 2'd2;

    typedef enum logic [1:0] {
        RSEL_T,
        RSEL_L,
        RSEL_R
    } rsel_t;

    typedef struct packed {
        logic  ready;
        logic  start;
        rsel_t rsel;
        logic  cap_t;
        logic  cap_l;
        logic  eval;
        logic  grant;
        logic  advance;
        logic  flush;
    } rnea_cmd_t;

    typedef struct packed {
        logic accepted;
        logic reject;
        logic second;
        logic grant_ok;
        logic out_free;
    } rnea_sts_t;

    function automatic ring_idx_t ring_left(input ring_idx_t s, input ring_idx_t n);
        return (s == '0) ? ring_idx_t'(n - 1'b1) : ring_idx_t'(s - 1'b1);
    endfunction

    function automatic ring_idx_t ring_right(input ring_idx_t s, input ring_idx_t n);
        return (ring_idx_t'(s + 1'b1) == n) ? '0 : ring_idx_t'(s + 1'b1);
    endfunction

endpackage

// ===== hdl/rnea_if.sv =====
interface rnea_req_if import rnea_pkg::*; ();
    logic      valid;
    logic      ready;
    logic      func;
    seat_idx_t seat;

    modport source (output valid, output func, output seat, input ready);
    modport sink   (input valid, input func, input seat, output ready);
endinterface

interface rnea_res_if import rnea_pkg::*; ();
    logic        valid;
    logic        ready;
    seat_idx_t   changed_seat;
    seat_state_t new_state;
    logic        rejected;
    logic        last;

    modport source (output valid, output changed_seat, output new_state, output rejected,
                    output last, input ready);
    modport sink   (input valid, input changed_seat, input new_state, input rejected,
                    input last, output ready);
endinterface

interface rnea_cfg_if import rnea_pkg::*; ();
    logic      valid;
    logic      ready;
    ring_idx_t seats_in_use;

    modport source (output valid, output seats_in_use, input ready);
    modport sink   (input valid, input seats_in_use, output ready);
endinterface

// ===== hdl/rnea_ram.sv =====
module rnea_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/rnea_ctrl.sv =====
module rnea_ctrl import rnea_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  rnea_sts_t sts,
    output rnea_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_RD_T,
        S_RD_L,
        S_RD_R,
        S_EVAL,
        S_GRANT,
        S_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rsel   = RSEL_T;
        case (state_reg)
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (sts.accepted)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.start  = 1'b1;
                state_next = sts.reject ? S_FLUSH : S_RD_T;
            end
            S_RD_T:
            begin
                cmd.rsel   = RSEL_T;
                state_next = S_RD_L;
            end
            S_RD_L:
            begin
                cmd.rsel   = RSEL_L;
                cmd.cap_t  = 1'b1;
                state_next = S_RD_R;
            end
            S_RD_R:
            begin
                cmd.rsel   = RSEL_R;
                cmd.cap_l  = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = S_GRANT;
            end
            S_GRANT:
            begin
                cmd.grant = 1'b1;
                if (!sts.grant_ok || sts.out_free)
                begin
                    cmd.advance = 1'b1;
                    state_next  = sts.second ? S_RD_T : S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                cmd.flush = 1'b1;
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/rnea_dp.sv =====
module rnea_dp import rnea_pkg::*; #(
    parameter int MAX_SEATS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    rnea_req_if.sink  req,
    rnea_res_if.source res,
    rnea_cfg_if.sink  cfg,
    input  rnea_cmd_t cmd,
    output rnea_sts_t sts
);

    localparam int AW   = $clog2(MAX_SEATS);
    localparam int NMAX = (MAX_SEATS < 31) ? MAX_SEATS : 31;
    localparam int NRST = (SEATS_RESET < NMAX) ? SEATS_RESET : NMAX;

    typedef logic [AW-1:0] addr_t;

    ring_idx_t      n_reg;
    ring_idx_t      n_next;
    logic           func_reg;
    seat_idx_t      seat_reg;
    ring_idx_t      tgt_reg;
    logic           second_reg;
    logic           vq_reg;
    seat_state_t    st_t_reg;
    seat_state_t    st_l_reg;
    logic           grant_reg;
    seat_idx_t      pend_seat_reg;
    seat_state_t    pend_state_reg;
    logic           pend_rej_reg;
    logic           out_valid_reg;
    seat_idx_t      out_seat_reg;
    seat_state_t    out_state_reg;
    logic           out_rej_reg;
    logic           out_last_reg;
    logic [MAX_SEATS-1:0] valid_reg;

    ring_idx_t   seat_ring;
    ring_idx_t   tgt_l;
    ring_idx_t   tgt_r;
    ring_idx_t   rd_ring;
    addr_t       raddr;
    addr_t       waddr;
    seat_state_t wdata;
    logic        we;
    seat_state_t ram_rdata;
    seat_state_t rd_state;
    logic        reject;
    logic        in_acc;
    logic        out_free;
    logic        do_grant;
    logic        do_flush;

    rnea_ram #(
        .WIDTH (STATE_W),
        .DEPTH (MAX_SEATS)
    ) u_state_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    assign req.ready = cmd.ready;
    assign cfg.ready = 1'b1;
    assign in_acc    = req.valid && req.ready;

    assign seat_ring = CFG_W'(seat_reg);
    assign reject    = (seat_ring >= n_reg);
    assign tgt_l     = ring_left(tgt_reg, n_reg);
    assign tgt_r     = ring_right(tgt_reg, n_reg);
    assign out_free  = !out_valid_reg || res.ready;
    assign do_grant  = cmd.grant && grant_reg && out_free;
    assign do_flush  = cmd.flush && out_free;
    assign rd_state  = vq_reg ? ram_rdata : ST_THINKING;

    always_comb
    begin
        case (cmd.rsel)
            RSEL_T:  rd_ring = tgt_reg;
            RSEL_L:  rd_ring = tgt_l;
            RSEL_R:  rd_ring = tgt_r;
            default: rd_ring = tgt_reg;
        endcase
    end

    assign raddr = addr_t'(rd_ring);

    always_comb
    begin
        we    = 1'b0;
        waddr = addr_t'(tgt_reg);
        wdata = ST_EATING;
        if (cmd.start && !reject)
        begin
            we    = 1'b1;
            waddr = addr_t'(seat_ring);
            wdata = func_reg ? ST_THINKING : ST_HUNGRY;
        end
        else if (do_grant)
        begin
            we = 1'b1;
        end
    end

    // clamp to 1..MAX_SEATS
    always_comb
    begin
        if (cfg.seats_in_use == '0)
        begin
            n_next = CFG_W'(1);
        end
        else if (int'(cfg.seats_in_use) > NMAX)
        begin
            n_next = CFG_W'(NMAX);
        end
        else
        begin
            n_next = cfg.seats_in_use;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= CFG_W'(NRST);
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            second_reg    <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                n_reg <= n_next;
            end
            if (do_grant || do_flush)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (cmd.start)
            begin
                second_reg <= func_reg;
            end
            else if (cmd.advance)
            begin
                second_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        vq_reg <= valid_reg[raddr];
        if (in_acc)
        begin
            func_reg <= req.func;
            seat_reg <= req.seat;
        end
        if (cmd.start)
        begin
            tgt_reg        <= func_reg ? ring_left(seat_ring, n_reg) : seat_ring;
            pend_seat_reg  <= seat_reg;
            pend_state_reg <= (reject || func_reg) ? ST_THINKING : ST_HUNGRY;
            pend_rej_reg   <= reject;
        end
        else if (do_grant)
        begin
            pend_seat_reg  <= SEAT_W'(tgt_reg);
            pend_state_reg <= ST_EATING;
            pend_rej_reg   <= 1'b0;
        end
        if (cmd.advance && second_reg)
        begin
            tgt_reg <= ring_right(seat_ring, n_reg);
        end
        if (cmd.cap_t)
        begin
            st_t_reg <= rd_state;
        end
        if (cmd.cap_l)
        begin
            st_l_reg <= rd_state;
        end
        if (cmd.eval)
        begin
            grant_reg <= (st_t_reg == ST_HUNGRY) && (st_l_reg != ST_EATING)
                         && (rd_state != ST_EATING);
        end
        if (do_grant || do_flush)
        begin
            out_seat_reg  <= pend_seat_reg;
            out_state_reg <= pend_state_reg;
            out_rej_reg   <= pend_rej_reg;
            out_last_reg  <= do_flush;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.changed_seat = out_seat_reg;
    assign res.new_state    = out_state_reg;
    assign res.rejected     = out_rej_reg;
    assign res.last         = out_last_reg;

    assign sts.accepted = in_acc;
    assign sts.reject   = reject;
    assign sts.second   = second_reg;
    assign sts.grant_ok = grant_reg;
    assign sts.out_free = out_free;

endmodule

// ===== hdl/ring_neighbour_exclusion_arbiter_top.sv =====
// Items are taken one at a time: a new request is accepted only when idle, after
// the final result of the last item is issued; pacing is set by the sequencer's
// serial reads of one state RAM port, and output stalls add to it.
// Reset (rst_n, async low): all seats thinking via per-seat valid bits,
// seats_in_use = 5 (clamped to MAX_SEATS), output empty, no clearing pass.
`include "ring_neighbour_exclusion_arbiter_top_macros.svh"

module ring_neighbour_exclusion_arbiter_top import rnea_pkg::*; #(
    parameter int MAX_SEATS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    rnea_req_if.sink   req,
    rnea_res_if.source res,
    rnea_cfg_if.sink   cfg
);

    rnea_cmd_t cmd;
    rnea_sts_t sts;

    rnea_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    rnea_dp #(
        .MAX_SEATS (MAX_SEATS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .res   (res),
        .cfg   (cfg),
        .cmd   (cmd),
        .sts   (sts)
    );

    `RNEA_ASSERT_NEXT(a_one_item, req.valid && req.ready, !req.ready, "item taken while busy")
    `RNEA_ASSERT_NOW(a_reject_form, res.valid && res.rejected,
                     res.last && (res.new_state == ST_THINKING), "bad reject result")
    `RNEA_ASSERT_NEXT(a_grant_out, cmd.grant && sts.grant_ok && sts.out_free,
                      res.valid && !res.last, "grant lost earlier result")
    `RNEA_ASSERT_NEXT(a_flush_out, cmd.flush && sts.out_free,
                      res.valid && res.last, "final result not marked")

endmodule
